// File: rtl/rpsz_pkg.sv
// shared types and constants for the rotated point splat z-buffer
`default_nettype none

package rpsz_pkg;

  localparam int RenderSizeDef = 128;

  // payload widths
  localparam int XW       = 7;
  localparam int YW       = 7;
  localparam int ZW       = 5;
  localparam int ColorW   = 16;
  localparam int IdxW     = 14;
  localparam int DepthW   = 16;
  localparam int TrigW    = 16;
  localparam int RadW     = 2;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  // datapath widths
  localparam int ProdW  = 24;          // x*cos + z*sin needs 23 bits signed
  localparam int MulW   = ProdW + 5;   // room for the times-17 scale
  localparam int CoordW = 12;          // signed screen coordinate
  localparam int OffW   = RadW + 1;    // signed splat offset

  localparam int ProjMul    = 17;
  localparam int ProjShift  = 18;      // divide by 262144
  localparam int DepthShift = 6;       // divide by 64

  localparam logic signed [DepthW-1:0] DepthEmpty = 16'sh8000;
  localparam logic signed [OffW-1:0]   OffOne     = 1;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSine   = 2'd0,
    CfgCosine = 2'd1,
    CfgRadius = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic signed [CoordW-1:0] sx;
    logic signed [CoordW-1:0] sy;
    logic signed [DepthW-1:0] depth;
  } rpsz_proj_t;

endpackage

`default_nettype wire

// File: rtl/rpsz_in_if.sv
// input channel: plot or clear commands
`default_nettype none

interface rpsz_in_if import rpsz_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    operation;
  logic signed [XW-1:0]    model_x;
  logic signed [YW-1:0]    model_y;
  logic signed [ZW-1:0]    model_z;
  logic        [ColorW-1:0] point_color;

  modport source (output valid, operation, model_x, model_y, model_z, point_color,
                  input ready);
  modport sink   (input valid, operation, model_x, model_y, model_z, point_color,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/rpsz_out_if.sv
// output channel: pixel writes
`default_nettype none

interface rpsz_out_if import rpsz_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [IdxW-1:0]   pixel_index;
  logic [ColorW-1:0] pixel_color;
  logic              last;

  modport source (output valid, pixel_index, pixel_color, last, input ready);
  modport sink   (input valid, pixel_index, pixel_color, last, output ready);
endinterface

`default_nettype wire

// File: rtl/rpsz_xform.sv
// rotation and projection of a model point, two register stages
`default_nettype none

module rpsz_xform import rpsz_pkg::*; #(
  parameter int RenderSize = RenderSizeDef
) (
  input  logic                     clk_i,
  input  logic                     load_i,
  input  logic                     step_i,
  input  logic signed [XW-1:0]     x_i,
  input  logic signed [YW-1:0]     y_i,
  input  logic signed [ZW-1:0]     z_i,
  input  logic signed [TrigW-1:0]  sine_i,
  input  logic signed [TrigW-1:0]  cos_i,
  output rpsz_proj_t               proj_o
);

  localparam logic signed [MulW-1:0]  ProjBias  = MulW'((1 << ProjShift) - 1);
  localparam logic signed [MulW-1:0]  MulZero   = '0;
  localparam logic signed [ProdW-1:0] DepthBias = ProdW'((1 << DepthShift) - 1);
  localparam logic signed [ProdW-1:0] ProdZero  = '0;
  localparam logic signed [MulW-1:0]  ProjMulS  = MulW'(ProjMul);
  localparam logic signed [CoordW-1:0] Center   = CoordW'(RenderSize / 2);

  logic signed [ProdW-1:0] xc_q, zs_q, xs_q, zc_q;
  logic signed [YW-1:0]    y_q;
  logic signed [ProdW-1:0] xc_d, zs_d, xs_d, zc_d;

  logic signed [ProdW-1:0]  rx, rz, rz_adj;
  logic signed [MulW-1:0]   rx_w, rx17, rx_adj, q_full;
  logic signed [ProdW-1:0]  dz_full;
  rpsz_proj_t               proj_d, proj_q;

  // stage one: four narrow products
  always_comb begin
    xc_d = ProdW'(x_i) * ProdW'(cos_i);
    zs_d = ProdW'(z_i) * ProdW'(sine_i);
    xs_d = ProdW'(x_i) * ProdW'(sine_i);
    zc_d = ProdW'(z_i) * ProdW'(cos_i);
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      xc_q <= xc_d;
      zs_q <= zs_d;
      xs_q <= xs_d;
      zc_q <= zc_d;
      y_q  <= y_i;
    end
  end

  // stage two: sums, scale and divisions truncating toward zero
  always_comb begin
    rx      = xc_q + zs_q;
    rz      = zc_q - xs_q;
    rx_w    = MulW'(rx);
    rx17    = rx_w * ProjMulS;
    rx_adj  = rx17 + (rx17[MulW-1] ? ProjBias : MulZero);
    q_full  = rx_adj >>> ProjShift;
    rz_adj  = rz + (rz[ProdW-1] ? DepthBias : ProdZero);
    dz_full = rz_adj >>> DepthShift;

    proj_d.sx    = CoordW'(q_full) + Center;
    proj_d.sy    = CoordW'(y_q) + Center;
    proj_d.depth = DepthW'(dz_full);
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      proj_q <= proj_d;
    end
  end

  assign proj_o = proj_q;

endmodule

`default_nettype wire

// File: rtl/rpsz_depth_mem.sv
// depth store: one write port, one registered read port
`default_nettype none

module rpsz_depth_mem import rpsz_pkg::*; #(
  parameter int Depth = RenderSizeDef * RenderSizeDef,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AddrW-1:0]  waddr_i,
  input  logic [DepthW-1:0] wdata_i,
  input  logic              re_i,
  input  logic [AddrW-1:0]  raddr_i,
  output logic [DepthW-1:0] rdata_o
);

  logic [DepthW-1:0] mem_q [Depth];
  logic [DepthW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/rotated_point_splat_zbuffer.sv
// top level: rotated point splat with depth test
//
// in_ch_i carries commands: operation 0 plots a point, operation 1 clears
// the depth store. out_ch_o carries one transaction per pixel that passes
// the depth test, last marking the final pixel of a point. both channels
// move a transaction when valid and ready are high at a rising edge.
// the config port writes sine, cosine and splat radius when cfg_we_i is high.
//
// a plot runs a transform state, a walk state (one depth read and compare
// per on-screen pixel of the (2r+1)^2 splat, a write where it passes) and
// a flush state; a new command is taken only once the block is back in
// idle. each passing pixel is held in the pending register until
// the next passing pixel shows it was not the last one.
// a pixel write reaches out_ch_o through the transform stages, the walk's
// issue and compare stages, the pending register and the output register.
// a clear sweeps all RenderSize^2 entries of the store one entry a cycle,
// 16384 at the default size; in_ch_i.ready stays low meanwhile.
// reset runs the same sweep before the first command is taken.
// when the receiver stalls, the walk halts on the pixel that would push
// a second result; the output register holds its transaction steady.
`default_nettype none

module rotated_point_splat_zbuffer import rpsz_pkg::*; #(
  parameter int RenderSize = RenderSizeDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  rpsz_in_if.sink             in_ch_i,
  rpsz_out_if.source          out_ch_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int StoreSize = RenderSize * RenderSize;
  localparam int AddrW     = $clog2(StoreSize);
  localparam int PixW      = $clog2(RenderSize);
  localparam logic signed [CoordW-1:0] SizeS   = CoordW'(RenderSize);
  localparam logic [AddrW-1:0]         ClrLast = AddrW'(StoreSize - 1);

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StMath  = 5'b00010,
    StWalk  = 5'b00100,
    StFlush = 5'b01000,
    StClear = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // config registers
  logic signed [TrigW-1:0] sine_q, cos_q;
  logic [RadW-1:0]         rad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sine_q <= '0;
      cos_q  <= 16'sh4000;
      rad_q  <= 2'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgSine:   sine_q <= cfg_data_i;
        CfgCosine: cos_q  <= cfg_data_i;
        CfgRadius: rad_q  <= cfg_data_i[RadW-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  logic in_fire;
  assign in_ch_i.ready = (state_q == StIdle);
  assign in_fire       = in_ch_i.valid && in_ch_i.ready;

  // transform unit
  rpsz_proj_t proj;

  rpsz_xform #(.RenderSize(RenderSize)) u_xform (
    .clk_i  (clk_i),
    .load_i (in_fire),
    .step_i (state_q == StMath),
    .x_i    (in_ch_i.model_x),
    .y_i    (in_ch_i.model_y),
    .z_i    (in_ch_i.model_z),
    .sine_i (sine_q),
    .cos_i  (cos_q),
    .proj_o (proj)
  );

  logic [ColorW-1:0] color_q;
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      color_q <= in_ch_i.point_color;
    end
  end

  // splat walk: issue stage computes the pixel address
  logic signed [OffW-1:0]   rad_s;
  logic signed [OffW-1:0]   ox_q, oy_q;
  logic                     iss_left_q;
  logic signed [CoordW-1:0] px, py;
  logic                     iss_on, walk_end;
  logic [AddrW-1:0]         iss_idx;

  assign rad_s    = $signed({1'b0, rad_q});
  assign px       = proj.sx + CoordW'(ox_q);
  assign py       = proj.sy + CoordW'(oy_q);
  assign iss_on   = !px[CoordW-1] && (px < SizeS) && !py[CoordW-1] && (py < SizeS);
  assign iss_idx  = AddrW'(py[PixW-1:0]) * AddrW'(RenderSize) + AddrW'(px[PixW-1:0]);
  assign walk_end = (ox_q == rad_s) && (oy_q == rad_s);

  // compare stage: read data arrives here in the cycle after issue
  logic                     cmp_v_q, cmp_on_q;
  logic [AddrW-1:0]         cmp_idx_q;
  logic signed [DepthW-1:0] rd_data;
  logic                     pass, stall, adv, slot_free;

  // pending pixel, emitted once its last flag is known
  logic             pend_v_q;
  logic [AddrW-1:0] pend_idx_q;
  logic             push_mid, push_end, push;

  // output register
  logic              out_v_q, out_last_q;
  logic [IdxW-1:0]   out_idx_q;
  logic [ColorW-1:0] out_color_q;

  assign slot_free = !out_v_q || out_ch_o.ready;
  assign pass      = cmp_v_q && cmp_on_q && (proj.depth >= rd_data);
  assign stall     = pass && pend_v_q && !slot_free;
  assign adv       = (state_q == StWalk) && !stall;
  assign push_mid  = adv && pass && pend_v_q;
  assign push_end  = (state_q == StFlush) && pend_v_q && slot_free;
  assign push      = push_mid || push_end;

  // depth store port selection: clearing sweep or depth update
  logic [AddrW-1:0]  clr_cnt_q;
  logic              mem_we, mem_re;
  logic [AddrW-1:0]  mem_waddr;
  logic [DepthW-1:0] mem_wdata;

  always_comb begin
    if (state_q == StClear) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_q;
      mem_wdata = DepthEmpty;
    end else begin
      mem_we    = adv && pass;
      mem_waddr = cmp_idx_q;
      mem_wdata = proj.depth;
    end
  end

  // off-screen pixels skip the read
  assign mem_re = adv && iss_left_q && iss_on;

  rpsz_depth_mem #(.Depth(StoreSize), .AddrW(AddrW)) u_depth_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (iss_idx),
    .rdata_o (rd_data)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          state_d = in_ch_i.operation ? StClear : StMath;
        end
      end
      StMath: state_d = StWalk;
      StWalk: begin
        // the last compare retires in the same cycle
        if (adv && !iss_left_q) begin
          state_d = StFlush;
        end
      end
      StFlush: begin
        if (!pend_v_q || slot_free) begin
          state_d = StIdle;
        end
      end
      StClear: begin
        if (clr_cnt_q == ClrLast) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StClear;
      clr_cnt_q  <= '0;
      ox_q       <= '0;
      oy_q       <= '0;
      iss_left_q <= 1'b0;
      cmp_v_q    <= 1'b0;
      pend_v_q   <= 1'b0;
    end else begin
      state_q <= state_d;

      if (state_q == StClear) begin
        clr_cnt_q <= clr_cnt_q + AddrW'(1);
      end else if (in_fire) begin
        clr_cnt_q <= '0;
      end

      if (in_fire) begin
        ox_q       <= -rad_s;
        oy_q       <= -rad_s;
        iss_left_q <= !in_ch_i.operation;
        cmp_v_q    <= 1'b0;
      end else if (adv) begin
        cmp_v_q <= iss_left_q;
        if (iss_left_q) begin
          if (walk_end) begin
            iss_left_q <= 1'b0;
          end
          if (ox_q == rad_s) begin
            ox_q <= -rad_s;
            oy_q <= oy_q + OffOne;
          end else begin
            ox_q <= ox_q + OffOne;
          end
        end
      end

      if (adv && pass) begin
        pend_v_q <= 1'b1;
      end else if (push_end) begin
        pend_v_q <= 1'b0;
      end
    end
  end

  // compare stage and pending payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      cmp_on_q  <= iss_on;
      cmp_idx_q <= iss_idx;
    end
    if (adv && pass) begin
      pend_idx_q <= cmp_idx_q;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (push) begin
      out_v_q <= 1'b1;
    end else if (out_ch_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      out_idx_q   <= IdxW'(pend_idx_q);
      out_color_q <= color_q;
      out_last_q  <= push_end;
    end
  end

  assign out_ch_o.valid       = out_v_q;
  assign out_ch_o.pixel_index = out_idx_q;
  assign out_ch_o.pixel_color = out_color_q;
  assign out_ch_o.last        = out_last_q;

endmodule

`default_nettype wire

// File: rtl/rpsz_checker.sv
// port-level checks for the splat block, bound to the top level
`default_nettype none

module rpsz_checker import rpsz_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [IdxW-1:0]   out_index_i,
  input logic [ColorW-1:0] out_color_i,
  input logic              out_last_i
);

  // a command always takes the block out of idle, so ready is low in the cycle after it is taken
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("ready high right after a command transaction");

  // while reset is held the block sits in the clearing state with nothing to show
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !in_ready_i && !out_valid_i)
    else $error("ready or valid high during reset");

  // a point never leaves its final pixel unmarked when the block goes idle
  a_idle_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i && out_valid_i |-> out_last_i)
    else $error("idle with an unmarked pixel transaction waiting");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_index_i)
      && $stable(out_color_i) && $stable(out_last_i))
    else $error("stalled pixel transaction changed");

endmodule

bind rotated_point_splat_zbuffer rpsz_checker u_rpsz_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_ch_i.valid),
  .in_ready_i  (in_ch_i.ready),
  .out_valid_i (out_ch_o.valid),
  .out_ready_i (out_ch_o.ready),
  .out_index_i (out_ch_o.pixel_index),
  .out_color_i (out_ch_o.pixel_color),
  .out_last_i  (out_ch_o.last)
);

`default_nettype wire

// File: verif/rotated_point_splat_zbuffer_tb.sv
// self-checking testbench for the rotated point splat z-buffer
`default_nettype none

module rotated_point_splat_zbuffer_tb;
  import rpsz_pkg::*;

  localparam int RenderSize = RenderSizeDef;
  localparam int StoreSize  = RenderSize * RenderSize;
  // a clear sweeps the store one entry per cycle; slack on top for a plot walk
  localparam int SweepCycles = StoreSize;
  localparam int SettleCycles = 200;

  // command codes on the input channel
  typedef enum logic {
    OpPlot  = 1'b0,
    OpClear = 1'b1
  } op_e;

  typedef struct packed {
    op_e                      op;
    logic signed [XW-1:0]     x;
    logic signed [YW-1:0]     y;
    logic signed [ZW-1:0]     z;
    logic        [ColorW-1:0] color;
  } cmd_t;

  typedef struct packed {
    logic [IdxW-1:0]   index;
    logic [ColorW-1:0] color;
    logic              last;
  } pixel_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  rpsz_in_if  cmd_ch ();
  rpsz_out_if pix_ch ();

  rotated_point_splat_zbuffer #(
    .RenderSize(RenderSize)
  ) u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_ch_i   (cmd_ch),
    .out_ch_o  (pix_ch),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // mirror of the block: rotation registers, radius and the depth store
  logic signed [TrigW-1:0]  sine_now;
  logic signed [TrigW-1:0]  cosine_now;
  logic        [RadW-1:0]   radius_now;
  logic signed [DepthW-1:0] depth_mirror [StoreSize];

  cmd_t   cmd_backlog [$];   // commands waiting for the driver
  pixel_t pixel_expect[$];   // pixel writes predicted but not yet seen

  int unsigned idle_pct = 10;  // chance in a hundred that a side idles
  bit          sweep_pending;  // a clear was queued since the last drain
  int          mismatches;
  int          plots_taken;
  int          clears_taken;
  int          pixels_checked;
  int          max_burst;

  // clear the whole depth mirror to the empty depth
  function automatic void wipe_depths();
    foreach (depth_mirror[i]) depth_mirror[i] = DepthEmpty;
  endfunction

  // rotate, project and splat one point against the depth mirror,
  // queueing every pixel that passes the depth test in walk order
  function automatic void splat_point(input logic signed [XW-1:0] x,
                                      input logic signed [YW-1:0] y,
                                      input logic signed [ZW-1:0] z,
                                      input logic [ColorW-1:0] color);
    longint                   rx, rz, col, row, px, py;
    logic signed [DepthW-1:0] depth;
    int                       rad;
    int                       idx;
    pixel_t                   hits[$];
    pixel_t                   hit;
    rx    = longint'(x) * longint'(cosine_now) + longint'(z) * longint'(sine_now);
    rz    = -longint'(x) * longint'(sine_now) + longint'(z) * longint'(cosine_now);
    // both divisions truncate toward zero, as longint division does
    col   = RenderSize / 2 + (rx * 17) / 262144;
    row   = RenderSize / 2 + longint'(y);
    depth = DepthW'(rz / 64);  // only the low bits survive on overflow
    rad   = int'(radius_now);
    for (int oy = -rad; oy <= rad; oy++) begin
      for (int ox = -rad; ox <= rad; ox++) begin
        px = col + ox;
        py = row + oy;
        if (px >= 0 && px < RenderSize && py >= 0 && py < RenderSize) begin
          idx = int'(py * RenderSize + px);
          // a tie passes, so the later point wins
          if (depth >= depth_mirror[idx]) begin
            depth_mirror[idx] = depth;
            hit.index = IdxW'(idx);
            hit.color = color;
            hit.last  = 1'b0;
            hits.push_back(hit);
          end
        end
      end
    end
    if (hits.size() != 0) begin
      hits[hits.size() - 1].last = 1'b1;
      if (hits.size() > max_burst) max_burst = hits.size();
    end
    foreach (hits[i]) pixel_expect.push_back(hits[i]);
  endfunction

  // driver: one transaction from the backlog at a time, random gaps between
  always @(posedge clk_i or negedge rst_ni) begin
    cmd_t nxt;
    if (!rst_ni) begin
      cmd_ch.valid <= 1'b0;
    end else begin
      // transaction accepted at this edge: update the mirror right away
      if (cmd_ch.valid && cmd_ch.ready) begin
        if (op_e'(cmd_ch.operation) == OpClear) begin
          wipe_depths();
          clears_taken++;
        end else begin
          splat_point(cmd_ch.model_x, cmd_ch.model_y, cmd_ch.model_z, cmd_ch.point_color);
          plots_taken++;
        end
      end
      if (!cmd_ch.valid || cmd_ch.ready) begin
        if (cmd_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
          nxt = cmd_backlog.pop_front();
          cmd_ch.valid       <= 1'b1;
          cmd_ch.operation   <= nxt.op;
          cmd_ch.model_x     <= nxt.x;
          cmd_ch.model_y     <= nxt.y;
          cmd_ch.model_z     <= nxt.z;
          cmd_ch.point_color <= nxt.color;
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: random stalls on ready, each pixel write checked in order
  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t want;
    if (!rst_ni) begin
      pix_ch.ready <= 1'b0;
    end else begin
      if (pix_ch.valid && pix_ch.ready) begin
        pixels_checked++;
        if (pixel_expect.size() == 0) begin
          $display("%0t: unexpected pixel write index %0d color %h last %b", $time,
                   pix_ch.pixel_index, pix_ch.pixel_color, pix_ch.last);
          mismatches++;
        end else begin
          want = pixel_expect.pop_front();
          if (pix_ch.pixel_index !== want.index) begin
            $display("%0t: pixel_index expected %0d actual %0d", $time,
                     want.index, pix_ch.pixel_index);
            mismatches++;
          end
          if (pix_ch.pixel_color !== want.color) begin
            $display("%0t: pixel_color expected %h actual %h", $time,
                     want.color, pix_ch.pixel_color);
            mismatches++;
          end
          if (pix_ch.last !== want.last) begin
            $display("%0t: last expected %b actual %b (index %0d)", $time,
                     want.last, pix_ch.last, want.index);
            mismatches++;
          end
        end
      end
      pix_ch.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // one register write through the config port, mirror updated alongside
  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      CfgSine:   sine_now   = data;
      CfgCosine: cosine_now = data;
      CfgRadius: radius_now = data[RadW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [TrigW-1:0] sine, input logic [TrigW-1:0] cosine,
                          input logic [RadW-1:0] rad);
    write_reg(CfgSine, sine);
    write_reg(CfgCosine, cosine);
    write_reg(CfgRadius, CfgDataW'(rad));
  endtask

  task automatic push_plot(input int x, input int y, input int z, input int color);
    cmd_t c;
    c.op    = OpPlot;
    c.x     = XW'(x);
    c.y     = YW'(y);
    c.z     = ZW'(z);
    c.color = ColorW'(color);
    cmd_backlog.push_back(c);
  endtask

  // clear with junk in the ignored fields
  task automatic push_clear();
    cmd_t c;
    c       = cmd_t'($urandom);
    c.op    = OpClear;
    c.color = ColorW'($urandom);
    cmd_backlog.push_back(c);
    sweep_pending = 1'b1;
  endtask

  // random commands: mostly plots, half of them clustered near the center
  // so that splats overlap and depth tests go both ways, a rare clear
  task automatic push_random(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(63) == 0) begin
        push_clear();
      end else if ($urandom_range(1) == 0) begin
        push_plot($urandom_range(7) - 4, $urandom_range(7) - 4, $urandom, $urandom);
      end else begin
        push_plot($urandom, $urandom, $urandom, $urandom);
      end
    end
  endtask

  // wait until every command is taken and every pixel seen, then let any
  // silent work (a clear sweep, a plot with no visible pixel) finish
  task automatic drain();
    while (cmd_backlog.size() != 0 || cmd_ch.valid || pixel_expect.size() != 0)
      @(negedge clk_i);
    repeat (sweep_pending ? SweepCycles + SettleCycles : SettleCycles) @(negedge clk_i);
    sweep_pending = 1'b0;
  endtask

  initial begin
    rst_ni             = 1'b1;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = CfgSine;
    cfg_data_i         = '0;
    cmd_ch.valid       = 1'b0;
    cmd_ch.operation   = OpPlot;
    cmd_ch.model_x     = '0;
    cmd_ch.model_y     = '0;
    cmd_ch.model_z     = '0;
    cmd_ch.point_color = '0;
    pix_ch.ready       = 1'b0;
    sine_now           = '0;
    cosine_now         = 16'sd16384;
    radius_now         = 2'd1;
    wipe_depths();
    // reset falls after every process is waiting on it
    #1 rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    // the block sweeps its store after reset before taking commands
    repeat (SweepCycles + SettleCycles) @(negedge clk_i);

    // reset values written back explicitly, directed corner points
    set_regs(16'sd0, 16'sd16384, 2'd1);
    push_clear();
    push_plot(0, 0, 0, 16'h0000);          // screen center
    push_plot(0, 0, 0, 16'hffff);          // same depth again: tie passes
    push_plot(0, 0, -16, 16'h1234);        // behind, loses everywhere
    push_plot(0, 0, 15, 16'habcd);         // in front, wins everywhere
    push_plot(-64, -64, -8, 16'h5555);     // projects left of the screen
    push_plot(63, 63, 7, 16'haaaa);        // projects right of the screen
    push_plot(-60, -64, 0, 16'h0f0f);      // clipped at the top left
    push_plot(60, 63, 8, 16'hf0f0);        // clipped at the bottom right
    push_plot(1, 5, -1, 16'h8001);         // projection truncation, positive
    push_plot(-1, 5, -1, 16'h7ffe);        // projection truncation, negative
    push_clear();
    push_plot(0, 0, 0, 16'h4321);          // store empty again after clear
    push_random(30);
    drain();

    // quarter turn, widest splat
    set_regs(16'sd16384, 16'sd0, 2'd3);
    push_plot(0, 0, 0, 16'h1111);          // full 7x7 splat
    push_plot(-64, -64, -16, 16'h2222);
    push_plot(63, 63, 15, 16'h3333);
    push_plot(63, -1, -16, 16'h4444);
    push_random(60);
    drain();

    // opposite quarter turn, single pixel
    set_regs(-16'sd16384, 16'sd0, 2'd0);
    push_random(60);
    drain();

    // half turn with no idling on either side
    idle_pct = 0;
    set_regs(16'sd0, -16'sd16384, 2'd2);
    push_random(60);
    drain();
    idle_pct = 10;

    // eighth turn
    set_regs(16'sd11585, 16'sd11585, 2'd1);
    push_random(60);
    drain();

    // register extremes beyond unit range: depth wraps in 16 bits
    set_regs(16'h8000, 16'h7fff, 2'd2);
    push_plot(63, 0, 15, 16'hdead);
    push_plot(-64, 0, -16, 16'hbeef);
    push_random(50);
    drain();

    // arbitrary register values
    set_regs(TrigW'($urandom), TrigW'($urandom), RadW'($urandom_range(3)));
    push_random(60);
    drain();

    // final settle before the verdict
    repeat (SettleCycles) @(negedge clk_i);
    if (pixel_expect.size() != 0) begin
      $display("%0t: %0d predicted pixel writes never arrived", $time, pixel_expect.size());
      mismatches++;
    end
    $display("covered %0d plots and %0d clears over 7 rotation/radius settings",
             plots_taken, clears_taken);
    $display("checked %0d pixel writes, largest burst %0d, %0d field errors",
             pixels_checked, max_burst, mismatches);
    if (mismatches == 0) begin
      $display("rotated_point_splat_zbuffer: match");
    end else begin
      $display("rotated_point_splat_zbuffer: mismatch");
    end
    $finish;
  end

  // watchdog, many times the slowest expected run
  initial begin
    #24000000;
    $display("%0t: run did not finish in time", $time);
    $display("rotated_point_splat_zbuffer: mismatch");
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
rtl/rpsz_pkg.sv
rtl/rpsz_in_if.sv
rtl/rpsz_out_if.sv
rtl/rpsz_xform.sv
rtl/rpsz_depth_mem.sv
rtl/rotated_point_splat_zbuffer.sv
rtl/rpsz_checker.sv
verif/rotated_point_splat_zbuffer_tb.sv
